// ===== hdl/ttte_pkg.sv =====
// Shared constants and derived widths for the thermocouple tip temperature estimator.
package ttte_pkg;

  // Field widths
  localparam int AdcW     = 12;
  localparam int WorkW    = 13;
  localparam int TipW     = 14;
  localparam int ColdW    = 10;
  localparam int AlarmW   = 2;
  localparam int InDataW  = 40;
  localparam int OutDataW = 32;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 12;

  // Accumulators and filters
  localparam int SamplesPerResult = 10;
  localparam int IdxW             = 4;
  localparam int SumW             = 16;
  localparam int MinW             = 13;
  localparam int AccW             = 16;
  localparam int MeanShift        = 3;
  localparam int ColdFilterShift  = 3;
  localparam int MinReset         = 5000;

  // Tip moving average weight and its reciprocal for acc / weight
  localparam int HotFilterWeight = 8;
  localparam int HotShiftL       = $clog2(HotFilterWeight);
  localparam int HotRecipShift   = AccW + HotShiftL;
  localparam logic [AccW:0] HotRecip =
    (AccW + 1)'((1 << HotRecipShift) / HotFilterWeight + 1);
  localparam logic [AccW-1:0] HotWeightV = AccW'(HotFilterWeight);
  localparam int AdW = $clog2((2 ** AccW - 1) / HotFilterWeight + 1);

  // Register reset values and indexes
  localparam int ZeroPointReset = 239;
  localparam int JumpReset      = 60;
  localparam logic [CfgIdxW-1:0] RegZeroPoint     = 1'd0;
  localparam logic [CfgIdxW-1:0] RegJumpThreshold = 1'd1;

  // Alarm codes
  localparam logic [AlarmW-1:0] AlarmNormal   = 2'd0;
  localparam logic [AlarmW-1:0] AlarmSensor   = 2'd1;
  localparam logic [AlarmW-1:0] AlarmOverTemp = 2'd2;

  // Saturation detection
  localparam int AdcFull         = 4095;
  localparam int NearFull        = 3800;
  localparam int FullCountLimit  = 60;
  localparam int NearCountLimit  = 10;
  localparam int CntW            = 16;

  // Cold junction conversion
  localparam int ColdScale  = 3300;
  localparam int ColdOffset = 500;
  localparam int ColdCap    = 400;

  // Setpoint compensation: 80 + (work - 1000) / 20 (70 at work = 1000), as ((|x| >> 2) * recip) >> shift
  localparam int CompBase     = 80;
  localparam int CompPivot    = 1000;
  localparam int CompPivotAdj = 10;
  localparam int CompW        = 9;
  localparam int Div5Shift    = 14;
  localparam logic [11:0] Div5Recip = 12'((1 << Div5Shift) / 5 + 1);

  // Tip conversion: (1000 * (ad - zp) + 806 * cold) / 806, toward zero
  localparam int TipScale      = 1000;
  localparam int TipDiv        = 806;
  localparam int NumW          = AdW + 12;
  localparam int MagW          = NumW - 1;
  localparam int TipRecipShift = MagW + $clog2(TipDiv);
  localparam longint unsigned TipRecipL =
    (64'd1 << TipRecipShift) / 64'(TipDiv) + 64'd1;
  localparam logic [MagW:0] TipRecip = (MagW + 1)'(TipRecipL);
  localparam int SplitW = 12;
  localparam int PhW    = (MagW - SplitW) + (MagW + 1);
  localparam int PlW    = SplitW + (MagW + 1);
  localparam int TotW   = 2 * MagW + 1;
  localparam int QW     = TotW - TipRecipShift;

endpackage

// ===== hdl/thermocouple_tip_temperature_estimator_top.sv =====
// Thermocouple tip temperature estimator: trimmed means, moving averages and alarm.
//
// Input stream: one item per ADC conversion (tip sample, cold junction sample,
// working setpoint). Every tenth accepted item closes a group and produces one
// result item (tip temperature, cold junction temperature, alarm); the other
// nine produce nothing. Only the setpoint of the closing item is used.
// Throughput: one input item per cycle while in_tready is high. Group sums,
// maxima and minima update in the accepting cycle; the group totals then run
// through a seven-register pipeline (trim, filters, scaling, counters, tip
// numerator, split reciprocal multiply) into the output register.
// The tip filter state written in one stage is read in the stage before it by
// the next group, which is always at least ten items behind.
// Stall: a waiting result holds only the output register; the pipeline and the
// input hold while the next result sits in the last stage behind it (in_tready).
// Configuration: zero_point (index 0) and jump_threshold (index 1) are written on
// the cfg channel, always ready; the user writes them only while no group is in
// flight, which the block itself does not enforce. Reset: synchronous, active low;
// clears the group, both filters, the saturation counters and the pipeline,
// sets the alarm to sensor error and loads the register defaults.
module thermocouple_tip_temperature_estimator_top
  import ttte_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,    // hot_sample[11:0], cold_sample[23:12], work_temp[36:24]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,   // tip_temp[13:0], cold_temp[23:14], alarm[25:24]
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers
  logic [AdcW-1:0] zp_r, thr_r;

  // Group accumulators
  logic [IdxW-1:0] idx_r;
  logic [SumW-1:0] hsum_r, csum_r;
  logic [AdcW-1:0] hmax_r, cmax_r;
  logic [MinW-1:0] hmin_r, cmin_r;

  // Pipeline valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, p_valid_r, out_valid_r;

  // Stage payloads
  logic [SumW-1:0]  g_hsum_r, g_csum_r;
  logic [AdcW-1:0]  g_hmax_r, g_cmax_r;
  logic [MinW-1:0]  g_hmin_r, g_cmin_r;
  logic [WorkW-1:0] g_wk_r;

  logic [AdcW-1:0]  m_hot_r, m_cold_r;
  logic [CompW-1:0] m_comp_r;
  logic             m_wk_nz_r;

  logic             filt_primed_r;
  logic [AccW-1:0]  hacc_r, cacc_r;
  logic [AdW-1:0]   hot_cur_r;
  logic [CompW-1:0] f_comp_r;
  logic             f_wk_nz_r;

  logic [AdW-1:0]          a_ad_r;
  logic signed [ColdW-1:0] a_cold_r;
  logic [CompW-1:0]        a_comp_r;
  logic                    a_wk_nz_r;

  logic [CntW-1:0]         fsc_r, nfc_r;
  logic [AdW-1:0]          c_ad_r;
  logic signed [ColdW-1:0] c_cold_r;

  logic [AlarmW-1:0]       alarm_r;
  logic signed [NumW-1:0]  n_num_r;
  logic signed [ColdW-1:0] n_cold_r;

  logic [PhW-1:0]          p_hi_r;
  logic [PlW-1:0]          p_lo_r;
  logic                    p_neg_r;
  logic signed [ColdW-1:0] p_cold_r;
  logic [AlarmW-1:0]       p_alarm_r;

  logic [TipW-1:0]         out_tip_r;
  logic signed [ColdW-1:0] out_cold_r;
  logic [AlarmW-1:0]       out_alarm_r;

  // Hold everything only when a finished result cannot enter the output register
  logic adv;
  assign adv        = !(p_valid_r && out_valid_r && !out_tready);
  assign in_tready  = adv;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW - TipW - ColdW - AlarmW)'(0), out_alarm_r, out_cold_r,
                       out_tip_r};

  // Input item fields
  logic [AdcW-1:0]  hs, cs;
  logic [WorkW-1:0] wk;
  assign hs = in_tdata[11:0];
  assign cs = in_tdata[23:12];
  assign wk = in_tdata[36:24];

  // Stage 0: accumulate
  logic [SumW-1:0] hsum_nxt, csum_nxt;
  logic [AdcW-1:0] hmax_nxt, cmax_nxt;
  logic [MinW-1:0] hmin_nxt, cmin_nxt;
  logic            last;
  assign hsum_nxt = hsum_r + SumW'(hs);
  assign csum_nxt = csum_r + SumW'(cs);
  assign hmax_nxt = (hs > hmax_r) ? hs : hmax_r;
  assign cmax_nxt = (cs > cmax_r) ? cs : cmax_r;
  assign hmin_nxt = (MinW'(hs) < hmin_r) ? MinW'(hs) : hmin_r;
  assign cmin_nxt = (MinW'(cs) < cmin_r) ? MinW'(cs) : cmin_r;
  assign last     = (idx_r == IdxW'(SamplesPerResult - 1));

  // Stage 1 -> 2: trimmed means (eight middle samples never exceed 15 bits)
  logic [SumW-1:0] htrim, ctrim;
  assign htrim = g_hsum_r - SumW'(g_hmax_r) - SumW'(g_hmin_r);
  assign ctrim = g_csum_r - SumW'(g_cmax_r) - SumW'(g_cmin_r);

  // Setpoint compensation, truncated toward zero
  logic signed [WorkW:0] wk_off;
  logic [WorkW-1:0]      wk_mag;
  logic [22:0]           div_prod;
  logic [CompW-1:0]      div_q, comp_nxt;
  assign wk_off   = $signed({1'b0, g_wk_r}) - $signed((WorkW + 1)'(CompPivot));
  assign wk_mag   = wk_off[WorkW] ? WorkW'(-wk_off) : wk_off[WorkW-1:0];
  assign div_prod = 23'(wk_mag[WorkW-1:2]) * 23'(Div5Recip);
  assign div_q    = div_prod[22:Div5Shift];

  always_comb begin
    priority if (g_wk_r == WorkW'(CompPivot)) begin
      comp_nxt = CompW'(CompBase - CompPivotAdj);
    end else if (wk_off[WorkW]) begin
      comp_nxt = CompW'(CompBase) - div_q;
    end else begin
      comp_nxt = CompW'(CompBase) + div_q;
    end
  end

  // Stage 2 -> 3: moving averages
  logic [AccW-1:0] cur16, hdiff, hacc_nxt, cacc_nxt;
  assign cur16 = AccW'(hot_cur_r);
  assign hdiff = (AccW'(m_hot_r) > cur16) ? AccW'(m_hot_r) - cur16 : cur16 - AccW'(m_hot_r);

  always_comb begin
    priority if (!filt_primed_r || hdiff > AccW'(thr_r)) begin
      hacc_nxt = AccW'(m_hot_r) * HotWeightV;
    end else begin
      hacc_nxt = hacc_r + AccW'(m_hot_r) - cur16;
    end
    if (!filt_primed_r) begin
      cacc_nxt = AccW'({m_cold_r, 3'b000});
    end else begin
      cacc_nxt = cacc_r + AccW'(m_cold_r) - (cacc_r >> ColdFilterShift);
    end
  end

  // Stage 3 -> 4: averages and cold junction conversion
  logic [2*AccW:0]         hprod;
  logic [AdW-1:0]          ad_nxt;
  logic [12:0]             cold_avg;
  logic [24:0]             cold_prod;
  logic signed [13:0]      cold_deg;
  logic signed [ColdW-1:0] cold_nxt;
  assign hprod     = (2 * AccW + 1)'(hacc_r) * (2 * AccW + 1)'(HotRecip);
  assign ad_nxt    = AdW'(hprod >> HotRecipShift);
  assign cold_avg  = cacc_r[AccW-1:ColdFilterShift];
  assign cold_prod = 25'(cold_avg) * 25'(ColdScale);
  assign cold_deg  = $signed({1'b0, cold_prod[24:12]}) - $signed(14'(ColdOffset));
  assign cold_nxt  = (cold_deg > $signed(14'(ColdCap))) ? ColdW'(ColdCap) : cold_deg[ColdW-1:0];

  // Stage 4 -> 5: saturation counters and compensation
  logic [CntW-1:0] fsc_nxt, nfc_nxt;
  logic [12:0]     comp_thr;
  logic [AdW-1:0]  adc_nxt;

  always_comb begin
    fsc_nxt = '0;
    nfc_nxt = nfc_r;
    if (a_ad_r == AdW'(AdcFull)) begin
      fsc_nxt = (fsc_r == '1) ? fsc_r : fsc_r + 1'b1;
    end else if (a_ad_r > AdW'(NearFull)) begin
      nfc_nxt = (nfc_r == '1) ? nfc_r : nfc_r + 1'b1;
    end else begin
      nfc_nxt = '0;
    end
  end

  assign comp_thr = 13'(a_comp_r) + 13'(zp_r);
  assign adc_nxt  = (a_wk_nz_r && (16'(a_ad_r) > 16'(comp_thr))) ?
                    a_ad_r - AdW'(a_comp_r) : a_ad_r;

  // Stage 5 -> 6: alarm and tip numerator
  logic [AlarmW-1:0]      alarm_nxt;
  logic signed [NumW-1:0] dz_w, cold_w, num_nxt;
  localparam logic signed [NumW-1:0] TipScaleS = NumW'(TipScale);
  localparam logic signed [NumW-1:0] TipDivS   = NumW'(TipDiv);

  always_comb begin
    alarm_nxt = alarm_r;
    priority if (fsc_r >= CntW'(FullCountLimit) && nfc_r == '0) begin
      alarm_nxt = AlarmSensor;
    end else if (fsc_r == '0 && nfc_r >= CntW'(NearCountLimit)) begin
      alarm_nxt = AlarmOverTemp;
    end else if (fsc_r < CntW'(FullCountLimit) && nfc_r < CntW'(NearCountLimit)) begin
      alarm_nxt = AlarmNormal;
    end else begin
      alarm_nxt = alarm_r;
    end
  end

  assign dz_w    = $signed(NumW'(c_ad_r)) - $signed(NumW'(zp_r));
  assign cold_w  = NumW'(c_cold_r);
  assign num_nxt = dz_w * TipScaleS + cold_w * TipDivS;

  // Stage 6 -> 7: magnitude and split reciprocal multiply
  logic [NumW-1:0] abs_num;
  logic [MagW-1:0] mag;
  assign abs_num = n_num_r[NumW-1] ? NumW'(-n_num_r) : NumW'(n_num_r);
  assign mag     = abs_num[MagW-1:0];

  // Stage 7 -> out: sum partials, restore sign
  logic [TotW-1:0] total;
  logic [QW-1:0]   quot, quot_s;
  assign total  = (TotW'(p_hi_r) << SplitW) + TotW'(p_lo_r);
  assign quot   = total[TotW-1:TipRecipShift];
  assign quot_s = p_neg_r ? (~quot + 1'b1) : quot;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_r  <= AdcW'(ZeroPointReset);
      thr_r <= AdcW'(JumpReset);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegZeroPoint:     zp_r  <= cfg_data;
        RegJumpThreshold: thr_r <= cfg_data;
      endcase
    end
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      hsum_r        <= '0;
      hmax_r        <= '0;
      hmin_r        <= MinW'(MinReset);
      csum_r        <= '0;
      cmax_r        <= '0;
      cmin_r        <= MinW'(MinReset);
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      v4_r          <= 1'b0;
      v5_r          <= 1'b0;
      v6_r          <= 1'b0;
      p_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      filt_primed_r <= 1'b0;
      hacc_r        <= '0;
      cacc_r        <= '0;
      fsc_r         <= '0;
      nfc_r         <= '0;
      alarm_r       <= AlarmSensor;
    end else begin
      if (adv) begin
        if (in_tvalid) begin
          if (last) begin
            // close the group and start a fresh one
            idx_r  <= '0;
            hsum_r <= '0;
            hmax_r <= '0;
            hmin_r <= MinW'(MinReset);
            csum_r <= '0;
            cmax_r <= '0;
            cmin_r <= MinW'(MinReset);
          end else begin
            idx_r  <= idx_r + 1'b1;
            hsum_r <= hsum_nxt;
            hmax_r <= hmax_nxt;
            hmin_r <= hmin_nxt;
            csum_r <= csum_nxt;
            cmax_r <= cmax_nxt;
            cmin_r <= cmin_nxt;
          end
        end
        v1_r      <= in_tvalid && last;
        v2_r      <= v1_r;
        v3_r      <= v2_r;
        v4_r      <= v3_r;
        v5_r      <= v4_r;
        v6_r      <= v5_r;
        p_valid_r <= v6_r;
        if (v2_r) begin
          filt_primed_r <= 1'b1;
          hacc_r        <= hacc_nxt;
          cacc_r        <= cacc_nxt;
        end
        if (v4_r) begin
          fsc_r <= fsc_nxt;
          nfc_r <= nfc_nxt;
        end
        if (v5_r) begin
          alarm_r <= alarm_nxt;
        end
      end
      // load the next result, or drop the one just taken
      priority if (adv && p_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_tvalid && last) begin
        g_hsum_r <= hsum_nxt;
        g_hmax_r <= hmax_nxt;
        g_hmin_r <= hmin_nxt;
        g_csum_r <= csum_nxt;
        g_cmax_r <= cmax_nxt;
        g_cmin_r <= cmin_nxt;
        g_wk_r   <= wk;
      end
      if (v1_r) begin
        m_hot_r   <= htrim[14:MeanShift];
        m_cold_r  <= ctrim[14:MeanShift];
        m_comp_r  <= comp_nxt;
        m_wk_nz_r <= (g_wk_r != '0);
      end
      if (v2_r) begin
        f_comp_r  <= m_comp_r;
        f_wk_nz_r <= m_wk_nz_r;
      end
      if (v3_r) begin
        a_ad_r    <= ad_nxt;
        hot_cur_r <= ad_nxt;
        a_cold_r  <= cold_nxt;
        a_comp_r  <= f_comp_r;
        a_wk_nz_r <= f_wk_nz_r;
      end
      if (v4_r) begin
        c_ad_r   <= adc_nxt;
        c_cold_r <= a_cold_r;
      end
      if (v5_r) begin
        n_num_r  <= num_nxt;
        n_cold_r <= c_cold_r;
      end
      if (v6_r) begin
        p_hi_r    <= PhW'(mag[MagW-1:SplitW]) * PhW'(TipRecip);
        p_lo_r    <= PlW'(mag[SplitW-1:0]) * PlW'(TipRecip);
        p_neg_r   <= n_num_r[NumW-1];
        p_cold_r  <= n_cold_r;
        p_alarm_r <= alarm_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv && p_valid_r) begin
      out_tip_r   <= quot_s[TipW-1:0];
      out_cold_r  <= p_cold_r;
      out_alarm_r <= p_alarm_r;
    end
  end

endmodule

// ===== hdl/ttte_checker.sv =====
// Port-level checker for the tip temperature estimator, bound to the top level.
module ttte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [0:0]  cfg_index,
  input logic [11:0] cfg_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The input is only held back by a stalled result.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled without a pending result");

  // Alarm never carries an unused code.
  a_alarm_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:24] != 2'd3)
    else $error("alarm code out of range");

  // Cold junction temperature is capped.
  a_cold_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[23:14]) <= 10'sd400)
    else $error("cold junction temperature above cap");

  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result present right after reset");

endmodule

bind thermocouple_tip_temperature_estimator_top ttte_checker u_ttte_checker (.*);
